FILE: hdl/afrl_pkg.sv
package afrl_pkg;

  localparam int unsigned NOW_W   = 40;
  localparam int unsigned TIME_W  = NOW_W + 1;
  localparam int unsigned SECS_W  = 16;
  localparam int unsigned MS_W    = 10;
  localparam int unsigned DELAY_W = SECS_W + MS_W;
  localparam int unsigned SAT_W   = 64;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned FLAG_W  = 8;
  localparam int unsigned FAIL_W  = 3;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned IDX_W   = 3;

  localparam logic [MS_W-1:0]   MS_PER_S      = MS_W'(1000);
  localparam logic [FAIL_W-1:0] FAILS_TO_LOCK = FAIL_W'(5);

  typedef enum logic [IDX_W-1:0] {
    REG_ENABLED        = 3'd0,
    REG_MIN_GOOD       = 3'd1,
    REG_FIX_SATS       = 3'd2,
    REG_NEED_FLAG_MASK = 3'd3,
    REG_COOLDOWN_S     = 3'd4,
    REG_RETRY_WARM_S   = 3'd5,
    REG_COLD_RETRY_S   = 3'd6,
    REG_BACKOFF_S      = 3'd7
  } reg_idx_t;

  typedef enum logic {
    CMD_POLL    = 1'b0,
    CMD_OUTCOME = 1'b1
  } cmd_t;

  typedef struct packed {
    logic              enabled;
    logic [CNT_W-1:0]  min_good;
    logic [CNT_W-1:0]  fix_sats;
    logic [FLAG_W-1:0] need_flag_mask;
    logic [SECS_W-1:0] cooldown_s;
    logic [SECS_W-1:0] retry_warm_s;
    logic [SECS_W-1:0] cold_retry_s;
    logic [SECS_W-1:0] backoff_s;
  } cfg_t;

  typedef struct packed {
    logic              cmd;
    logic [NOW_W-1:0]  now_ms;
    logic              fetch_allowed;
    logic              link_ready;
    logic              inv_valid;
    logic [SAT_W-1:0]  stored_mask;
    logic [SAT_W-1:0]  good_mask;
    logic [CNT_W-1:0]  healthy_count;
    logic [FLAG_W-1:0] rx_flags;
    logic              response_ok;
    logic [CNT_W-1:0]  orbits_written;
    logic              time_written;
  } item_t;

  typedef struct packed {
    logic              attempt;
    logic [FLAG_W-1:0] request_flags;
    logic [SAT_W-1:0]  request_mask;
    logic              supply_ok;
    logic [FAIL_W-1:0] fail_count;
  } result_t;

endpackage

FILE: hdl/afrl_cfg.sv
module afrl_cfg
  import afrl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             we,
  input  logic [IDX_W-1:0] index,
  input  logic [CFG_W-1:0] data,
  output cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled        <= 1'b1;
      cfg.min_good       <= CNT_W'(6);
      cfg.fix_sats       <= CNT_W'(4);
      cfg.need_flag_mask <= '0;
      cfg.cooldown_s     <= SECS_W'(1800);
      cfg.retry_warm_s   <= SECS_W'(60);
      cfg.cold_retry_s   <= SECS_W'(15);
      cfg.backoff_s      <= SECS_W'(900);
    end else if (we) begin
      unique case (reg_idx_t'(index))
        REG_ENABLED:        cfg.enabled        <= data[0];
        REG_MIN_GOOD:       cfg.min_good       <= data[CNT_W-1:0];
        REG_FIX_SATS:       cfg.fix_sats       <= data[CNT_W-1:0];
        REG_NEED_FLAG_MASK: cfg.need_flag_mask <= data[FLAG_W-1:0];
        REG_COOLDOWN_S:     cfg.cooldown_s     <= data[SECS_W-1:0];
        REG_RETRY_WARM_S:   cfg.retry_warm_s   <= data[SECS_W-1:0];
        REG_COLD_RETRY_S:   cfg.cold_retry_s   <= data[SECS_W-1:0];
        REG_BACKOFF_S:      cfg.backoff_s      <= data[SECS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/afrl_in_stage.sv
module afrl_in_stage
  import afrl_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  item_t in_item,
  input  logic  advance,
  output logic  in_stall,
  output logic  held_valid,
  output item_t held_item
);

  logic load;

  // The slot frees up in the same cycle its transaction moves on.
  assign in_stall = held_valid && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_item <= in_item;
    end
  end

endmodule

FILE: hdl/afrl_core.sv
module afrl_core
  import afrl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    advance,
  input  item_t   item,
  output result_t result
);

  logic [TIME_W-1:0] next_attempt_time, next_attempt_time_next;
  logic              need_any, need_any_next;
  logic              need_orbits, need_orbits_next;
  logic [FLAG_W-1:0] saved_flags, saved_flags_next;
  logic [SAT_W-1:0]  saved_mask, saved_mask_next;
  logic [FAIL_W-1:0] fails_in_row, fails_in_row_next;
  logic              failing_episode, failing_episode_next;
  logic              locked, locked_next;
  logic              cold, cold_next;

  logic              gate;
  logic              attempt;
  logic              ok;
  logic [SECS_W-1:0] retry_s;
  logic [SECS_W-1:0] delay_s;
  logic [DELAY_W-1:0] delay_ms;
  logic [FAIL_W-1:0] fails_inc;

  assign gate = cfg.enabled && item.fetch_allowed && item.link_ready &&
                ({1'b0, item.now_ms} >= next_attempt_time);

  assign ok = item.response_ok &&
              !(need_orbits && (item.orbits_written == '0)) &&
              ((item.orbits_written != '0) || item.time_written);

  assign retry_s   = cold ? cfg.cold_retry_s : cfg.retry_warm_s;
  assign fails_inc = fails_in_row + FAIL_W'(1);
  assign delay_ms  = DELAY_W'(delay_s) * DELAY_W'(MS_PER_S);

  always_comb begin
    next_attempt_time_next = next_attempt_time;
    need_any_next          = need_any;
    need_orbits_next       = need_orbits;
    saved_flags_next       = saved_flags;
    saved_mask_next        = saved_mask;
    fails_in_row_next      = fails_in_row;
    failing_episode_next   = failing_episode;
    locked_next            = locked;
    cold_next              = cold;
    attempt                = 1'b0;
    delay_s                = retry_s;

    if (item.cmd == CMD_POLL) begin
      if (gate) begin
        if (item.inv_valid) begin
          saved_mask_next  = item.stored_mask & ~item.good_mask;
          saved_flags_next = item.rx_flags;
          cold_next        = item.healthy_count < cfg.fix_sats;
          need_orbits_next = item.healthy_count < cfg.min_good;
          need_any_next    = need_orbits_next ||
                             ((item.rx_flags & cfg.need_flag_mask) != '0);
        end
        attempt = need_any_next;
      end
    end else begin
      if (ok) begin
        failing_episode_next = 1'b0;
        locked_next          = 1'b0;
        fails_in_row_next    = '0;
        delay_s              = cfg.cooldown_s;
      end else if (!failing_episode) begin
        failing_episode_next = 1'b1;
        fails_in_row_next    = FAIL_W'(1);
      end else if (fails_inc >= FAILS_TO_LOCK) begin
        locked_next       = 1'b1;
        fails_in_row_next = '0;
        delay_s           = cfg.backoff_s;
      end else begin
        fails_in_row_next = fails_inc;
      end
      next_attempt_time_next = {1'b0, item.now_ms} + TIME_W'(delay_ms);
    end
  end

  always_comb begin
    result.attempt       = attempt;
    result.request_flags = attempt ? saved_flags_next : '0;
    result.request_mask  = attempt ? saved_mask_next : '0;
    result.supply_ok     = cfg.enabled && !locked_next;
    result.fail_count    = fails_in_row_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_attempt_time <= '0;
      need_any          <= 1'b0;
      need_orbits       <= 1'b0;
      saved_flags       <= '0;
      saved_mask        <= '0;
      fails_in_row      <= '0;
      failing_episode   <= 1'b0;
      locked            <= 1'b0;
      cold              <= 1'b1;
    end else if (advance) begin
      next_attempt_time <= next_attempt_time_next;
      need_any          <= need_any_next;
      need_orbits       <= need_orbits_next;
      saved_flags       <= saved_flags_next;
      saved_mask        <= saved_mask_next;
      fails_in_row      <= fails_in_row_next;
      failing_episode   <= failing_episode_next;
      locked            <= locked_next;
      cold              <= cold_next;
    end
  end

endmodule

FILE: hdl/afrl_out_stage.sv
module afrl_out_stage
  import afrl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    held_valid,
  input  result_t next_result,
  input  logic    out_stall,
  output logic    advance,
  output logic    out_valid,
  output result_t out_result
);

  assign advance = held_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= next_result;
    end
  end

endmodule

FILE: hdl/assist_fetch_retry_lockout_top.sv
// Assistance fetch pacing with retry and lockout.
// Two kinds of transaction arrive on the input channel: a poll (cmd 0) that
// carries the time, the gate bits and a satellite inventory, and an outcome
// report (cmd 1) that says how the last fetch went. Every input transaction
// produces exactly one result transaction, in order, on the output channel.
// Both channels use valid and stall; a transaction moves on a rising edge
// with valid high and stall low.
// A transaction passes two registers: the input register, where the pacing
// state is read and updated, and the result register. Throughput is one
// transaction per cycle while out_stall stays low; the only loop is the
// pacing state, which is updated as an item leaves the input register.
// When the receiver stalls, the result register holds its transaction and
// the input register can still take one more; after that in_stall rises.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data) and
// should be written only while no transaction is in flight.
// Reset (rst, synchronous) empties both registers, loads the register
// defaults and puts the pacing state at boot values with a cold inventory.
module assist_fetch_retry_lockout_top
  import afrl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,

  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,

  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cmd,
  input  logic [NOW_W-1:0]  now_ms,
  input  logic              fetch_allowed,
  input  logic              link_ready,
  input  logic              inv_valid,
  input  logic [SAT_W-1:0]  stored_mask,
  input  logic [SAT_W-1:0]  good_mask,
  input  logic [CNT_W-1:0]  healthy_count,
  input  logic [FLAG_W-1:0] rx_flags,
  input  logic              response_ok,
  input  logic [CNT_W-1:0]  orbits_written,
  input  logic              time_written,

  output logic              out_valid,
  input  logic              out_stall,
  output logic              attempt,
  output logic [FLAG_W-1:0] request_flags,
  output logic [SAT_W-1:0]  request_mask,
  output logic              supply_ok,
  output logic [FAIL_W-1:0] fail_count
);

  cfg_t    cfg;
  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    advance;
  result_t next_result;
  result_t out_result;

  // Gather the input ports into one transaction word.
  always_comb begin
    in_item.cmd            = cmd;
    in_item.now_ms         = now_ms;
    in_item.fetch_allowed  = fetch_allowed;
    in_item.link_ready     = link_ready;
    in_item.inv_valid      = inv_valid;
    in_item.stored_mask    = stored_mask;
    in_item.good_mask      = good_mask;
    in_item.healthy_count  = healthy_count;
    in_item.rx_flags       = rx_flags;
    in_item.response_ok    = response_ok;
    in_item.orbits_written = orbits_written;
    in_item.time_written   = time_written;
  end

  afrl_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  afrl_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .advance    (advance),
    .in_stall   (in_stall),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // The pacing state commits only when the held transaction moves into the
  // result register, so a stalled item is never applied twice.
  afrl_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .item    (held_item),
    .result  (next_result)
  );

  afrl_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .held_valid  (held_valid),
    .next_result (next_result),
    .out_stall   (out_stall),
    .advance     (advance),
    .out_valid   (out_valid),
    .out_result  (out_result)
  );

  assign attempt       = out_result.attempt;
  assign request_flags = out_result.request_flags;
  assign request_mask  = out_result.request_mask;
  assign supply_ok     = out_result.supply_ok;
  assign fail_count    = out_result.fail_count;

endmodule
